FILE: rtl/core/bbg_pkg.sv
// ---------------------------------------------------------------------------
// bbg_pkg: shared types and constants for the board bus glue decoder
// Target codes, request kinds, register indexes, address map and reset values.
// ---------------------------------------------------------------------------
package bbg_pkg;

  // Request kind carried in tuser
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  // Decoded target of a request
  typedef enum logic [4:0] {
    TGT_RAM        = 5'd0,
    TGT_ROM        = 5'd1,
    TGT_METER_RD   = 5'd2,
    TGT_UART       = 5'd3,
    TGT_SWITCH     = 5'd4,
    TGT_OPTOS      = 5'd5,
    TGT_SND_STATUS = 5'd6,
    TGT_HERE       = 5'd7,
    TGT_UNMAPPED   = 5'd8,
    TGT_SND_CHIP   = 5'd9,
    TGT_LAMP       = 5'd10,
    TGT_REEL12     = 5'd11,
    TGT_REEL34     = 5'd12,
    TGT_REEL56     = 5'd13,
    TGT_PLAY       = 5'd14,
    TGT_STOP       = 5'd15,
    TGT_METER_WR   = 5'd16,
    TGT_ALPHA      = 5'd17,
    TGT_KICK       = 5'd18,
    TGT_NONE       = 5'd19
  } target_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DIP_ONE    = 3'd0,
    CFG_DIP_TWO    = 3'd1,
    CFG_IRQ_PERIOD = 3'd2,
    CFG_WD_RELOAD  = 3'd3,
    CFG_WD_DIVIDER = 3'd4
  } cfg_idx_e;

  localparam int unsigned RamBytesDefault = 8192;
  localparam int unsigned CfgDataW        = 12;

  // Address map
  localparam logic [15:0] AddrRamTop    = 16'h2000;
  localparam logic [15:0] AddrRomLow    = 16'h4000;
  localparam logic [15:0] AddrKickLow   = 16'h8000;
  localparam logic [15:0] AddrReel34    = 16'h2000;
  localparam logic [15:0] AddrReel12    = 16'h2200;
  localparam logic [15:0] AddrAlpha     = 16'h2400;
  localparam logic [15:0] AddrMeter     = 16'h2600;
  localparam logic [15:0] AddrMuxOne    = 16'h2a00;
  localparam logic [15:0] AddrLampLo    = 16'h2a01;
  localparam logic [15:0] AddrLampHi    = 16'h2a02;
  localparam logic [15:0] AddrConst     = 16'h2e00;
  localparam logic [15:0] AddrSndChip0  = 16'h3001;
  localparam logic [15:0] AddrSndChip1  = 16'h3201;
  localparam logic [15:0] AddrUart0     = 16'h3406;
  localparam logic [15:0] AddrUart1     = 16'h3407;
  localparam logic [15:0] AddrMuxTwo    = 16'h3408;
  localparam logic [15:0] AddrLampLo2   = 16'h3409;
  localparam logic [15:0] AddrLampHi2   = 16'h340a;
  localparam logic [15:0] AddrPage      = 16'h3600;
  localparam logic [15:0] AddrReel56a   = 16'h3800;
  localparam logic [15:0] AddrSound     = 16'h3801;
  localparam logic [15:0] AddrReel56b   = 16'h3900;

  // Magic bytes and sound command fields
  localparam logic [7:0] MagicReel12    = 8'h46;
  localparam logic [7:0] MagicReel34    = 8'h42;
  localparam logic [1:0] SndCmdTag      = 2'b10;
  localparam logic [5:0] SndStopCode    = 6'h3f;
  localparam logic [7:0] ConstAnswer    = 8'd3;

  // Lamp bank offsets
  localparam logic [7:0] LampBaseLo     = 8'd0;
  localparam logic [7:0] LampBaseLo2    = 8'd8;
  localparam logic [7:0] LampBaseHi     = 8'd128;
  localparam logic [7:0] LampBaseHi2    = 8'd136;

  // Reset values
  localparam logic [1:0]  PageReset     = 2'd3;
  localparam logic [2:0]  LockReset     = 3'b111;
  localparam logic [11:0] IrqPeriodRst  = 12'd2000;
  localparam logic [8:0]  WdReloadRst   = 9'd500;
  localparam logic [9:0]  WdDividerRst  = 10'd1000;

  // Lock bit positions
  localparam int unsigned LockReel12    = 0;
  localparam int unsigned LockReel34    = 1;
  localparam int unsigned LockMeter     = 2;

  // Result tdata layout, lowest bit first
  localparam int unsigned OutTargetLsb  = 0;
  localparam int unsigned OutPhysLsb    = 5;
  localparam int unsigned OutColLsb     = 21;
  localparam int unsigned OutBaseLsb    = 25;
  localparam int unsigned OutFwdLsb     = 33;
  localparam int unsigned OutRdLsb      = 41;
  localparam int unsigned OutSndLsb     = 49;
  localparam int unsigned OutIrqBit     = 55;
  localparam int unsigned OutFirqBit    = 56;
  localparam int unsigned OutRstBit     = 57;
  localparam int unsigned OutDataW      = 64;
  localparam int unsigned InDataW       = 32;

endpackage

FILE: rtl/core/board_bus_glue_decoder.sv
// ---------------------------------------------------------------------------
// board_bus_glue_decoder: bus glue of an 8-bit CPU board
// Decodes bus reads and writes into a target and physical address, keeps the
// page and mux latches, reel/meter locks, periodic IRQ and watchdog.
// ---------------------------------------------------------------------------
// Path: an accepted request enters the input register; decode and state update
//   then write its result into the result register.
// Throughput: one request per cycle unless the result side stalls; the state
//   update of one request is a single pass, so the next follows without a gap.
// Reset (rst_ni low): all latches, counters, locks and pipeline valids clear
//   to their power-up values at once; configuration returns to its defaults.
module board_bus_glue_decoder
  import bbg_pkg::*;
#(
  parameter int unsigned RAM_BYTES = RamBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] bus_address, [23:16] store_byte, [28:24] cycle_count, [31:29] zero
  input  logic [InDataW-1:0]   s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]           s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [4:0] target, [20:5] physical_address, [24:21] lamp_column,
  // [32:25] lamp_base, [40:33] forward_data, [48:41] read_data,
  // [54:49] sound_index, [55] irq_level, [56] firq_pulse,
  // [57] reset_request, [63:58] zero
  output logic [OutDataW-1:0]  m_axis_tdata,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [7:0]  dip_one_q, dip_two_q;
  logic [11:0] irq_period_q;
  logic [8:0]  wd_reload_q;
  logic [9:0]  wd_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_one_q    <= '0;
      dip_two_q    <= '0;
      irq_period_q <= IrqPeriodRst;
      wd_reload_q  <= WdReloadRst;
      wd_div_q     <= WdDividerRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIP_ONE:    dip_one_q    <= cfg_data_i[7:0];
        CFG_DIP_TWO:    dip_two_q    <= cfg_data_i[7:0];
        CFG_IRQ_PERIOD: irq_period_q <= cfg_data_i[11:0];
        CFG_WD_RELOAD:  wd_reload_q  <= cfg_data_i[8:0];
        CFG_WD_DIVIDER: wd_div_q     <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Input register
  // -------------------------------------------------------------------------
  logic        in_valid_q;
  kind_e       kind_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic [4:0]  cyc_q;
  logic        out_valid_q;
  logic        advance;

  // stage 1 hands its request to the result register when that one frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q  <= kind_e'(s_axis_tuser);
      addr_q  <= s_axis_tdata[15:0];
      wdata_q <= s_axis_tdata[23:16];
      cyc_q   <= s_axis_tdata[28:24];
    end
  end

  // -------------------------------------------------------------------------
  // Board state (only the latch bits that are ever looked at are kept)
  // -------------------------------------------------------------------------
  logic [1:0]  page_q, page_d;
  logic [3:0]  mux_one_q, mux_one_d;
  logic [3:0]  mux_two_q, mux_two_d;
  logic [2:0]  lock_q, lock_d;
  logic [8:0]  wd_q, wd_d;
  logic [9:0]  tdiv_q, tdiv_d;
  logic [11:0] irq_cnt_q, irq_cnt_d;
  logic        irq_pend_q, irq_pend_d;
  logic        firq_pend_q, firq_pend_d;

  // -------------------------------------------------------------------------
  // RAM index: address modulo RAM_BYTES over the 8 KB RAM window. The
  // compares against each multiple are independent; the last hit wins.
  // -------------------------------------------------------------------------
  logic [15:0] ram_index;

  always_comb begin
    ram_index = {3'd0, addr_q[12:0]};
    for (int k = 1; k < 8; k++) begin
      if ({5'd0, addr_q[12:0]} >= 18'(k * RAM_BYTES)) begin
        ram_index = 16'({5'd0, addr_q[12:0]} - 18'(k * RAM_BYTES));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Decode and state update
  // -------------------------------------------------------------------------
  target_e     tgt;
  logic [15:0] phys;
  logic [3:0]  col;
  logic [7:0]  base;
  logic [7:0]  fwd;
  logic [7:0]  rd;
  logic [5:0]  snd;
  logic        firq_out;
  logic        rst_req;
  logic [9:0]  tdiv_inc;
  logic [12:0] irq_sum;

  always_comb begin
    tgt         = TGT_NONE;
    phys        = '0;
    col         = '0;
    base        = '0;
    fwd         = '0;
    rd          = '0;
    snd         = '0;
    firq_out    = 1'b0;
    rst_req     = 1'b0;
    page_d      = page_q;
    mux_one_d   = mux_one_q;
    mux_two_d   = mux_two_q;
    lock_d      = lock_q;
    wd_d        = wd_q;
    tdiv_d      = tdiv_q;
    irq_cnt_d   = irq_cnt_q;
    irq_pend_d  = irq_pend_q;
    firq_pend_d = firq_pend_q;
    tdiv_inc    = tdiv_q + 10'd1;
    irq_sum     = {1'b0, irq_cnt_q} + {8'd0, cyc_q};

    case (kind_q)
      KIND_READ: begin
        if (addr_q < AddrRamTop) begin
          tgt  = TGT_RAM;
          phys = ram_index;
        end else if (addr_q inside {[16'h6000:16'h7fff]}) begin
          // banked ROM window
          tgt  = TGT_ROM;
          phys = {1'b0, page_q, addr_q[12:0]};
        end else if (addr_q >= AddrRomLow) begin
          tgt  = TGT_ROM;
          phys = addr_q;
        end else begin
          case (addr_q)
            AddrMeter:   tgt = TGT_METER_RD;
            AddrUart0:   tgt = TGT_UART;
            AddrUart1: begin
              tgt  = TGT_UART;
              phys = 16'd1;
            end
            AddrMuxOne: begin
              // rows 7 and 6 answer with the switch banks
              if (mux_one_q[2:0] == 3'd7) begin
                tgt = TGT_HERE;
                rd  = dip_one_q;
              end else if (mux_one_q[2:0] == 3'd6) begin
                tgt = TGT_HERE;
                rd  = dip_two_q;
              end else begin
                tgt  = TGT_SWITCH;
                phys = {13'd0, mux_one_q[2:0]};
              end
            end
            AddrMuxTwo:  tgt = TGT_OPTOS;
            AddrConst: begin
              tgt = TGT_HERE;
              rd  = ConstAnswer;
            end
            AddrSound:   tgt = TGT_SND_STATUS;
            default:     tgt = TGT_UNMAPPED;
          endcase
        end
      end

      KIND_WRITE: begin
        fwd = wdata_q;
        if (addr_q < AddrRamTop) begin
          tgt  = TGT_RAM;
          phys = ram_index;
        end else if (addr_q >= AddrKickLow) begin
          // watchdog kick also acknowledges the IRQ
          tgt        = TGT_KICK;
          irq_pend_d = 1'b0;
          wd_d       = wd_reload_q;
        end else begin
          case (addr_q)
            AddrPage: begin
              tgt    = TGT_HERE;
              page_d = wdata_q[1:0];
            end
            AddrSndChip0: tgt = TGT_SND_CHIP;
            AddrSndChip1: begin
              tgt  = TGT_SND_CHIP;
              phys = 16'd1;
            end
            AddrMuxOne: begin
              tgt       = TGT_HERE;
              mux_one_d = wdata_q[3:0];
            end
            AddrLampLo: begin
              if (mux_one_q[3]) begin
                tgt  = TGT_LAMP;
                col  = {mux_one_q[2:0], 1'b0};
                base = LampBaseLo;
              end
            end
            AddrLampHi: begin
              if (mux_one_q[3]) begin
                tgt  = TGT_LAMP;
                col  = {mux_two_q[2:0], 1'b0};
                base = LampBaseHi;
              end
            end
            AddrUart0:    tgt = TGT_UART;
            AddrUart1: begin
              tgt  = TGT_UART;
              phys = 16'd1;
            end
            AddrMuxTwo: begin
              tgt       = TGT_HERE;
              mux_two_d = wdata_q[3:0];
            end
            AddrLampLo2: begin
              if (mux_two_q[3]) begin
                tgt  = TGT_LAMP;
                col  = {mux_one_q[2:0], 1'b0};
                base = LampBaseLo2;
              end
            end
            AddrLampHi2: begin
              if (mux_two_q[3]) begin
                tgt  = TGT_LAMP;
                col  = {mux_two_q[2:0], 1'b0};
                base = LampBaseHi2;
              end
            end
            AddrReel12: begin
              if (lock_q[LockReel12]) begin
                tgt = TGT_HERE;
                if (wdata_q == MagicReel12) lock_d[LockReel12] = 1'b0;
              end else begin
                tgt = TGT_REEL12;
              end
            end
            AddrReel34: begin
              if (lock_q[LockReel34]) begin
                tgt = TGT_HERE;
                if (wdata_q == MagicReel34) lock_d[LockReel34] = 1'b0;
              end else begin
                tgt = TGT_REEL34;
              end
            end
            AddrReel56a, AddrReel56b: tgt = TGT_REEL56;
            AddrSound: begin
              if (wdata_q[7:6] == SndCmdTag) begin
                if (wdata_q[5:0] == SndStopCode) begin
                  tgt = TGT_STOP;
                end else begin
                  tgt = TGT_PLAY;
                  snd = wdata_q[5:0];
                end
              end
            end
            AddrMeter: begin
              // first meter write only opens the lock
              if (lock_q[LockMeter]) begin
                tgt               = TGT_HERE;
                lock_d[LockMeter] = 1'b0;
              end else begin
                tgt = TGT_METER_WR;
                if (wdata_q != 8'd0) firq_pend_d = 1'b1;
              end
            end
            AddrAlpha:    tgt = TGT_ALPHA;
            default:      tgt = TGT_UNMAPPED;
          endcase
        end
      end

      KIND_TICK: begin
        // watchdog prescaler
        if (tdiv_inc >= wd_div_q) begin
          tdiv_d = '0;
          if (wd_q != 9'd0) begin
            wd_d = wd_q - 9'd1;
            if (wd_q == 9'd1) rst_req = 1'b1;
          end
        end else begin
          tdiv_d = tdiv_inc;
        end

        if (rst_req) begin
          // board reset: state back to power-up, tick cycles dropped
          page_d      = PageReset;
          mux_one_d   = '0;
          mux_two_d   = '0;
          lock_d      = LockReset;
          wd_d        = '0;
          tdiv_d      = '0;
          irq_cnt_d   = '0;
          irq_pend_d  = 1'b0;
          firq_pend_d = 1'b0;
        end else begin
          if (irq_sum >= {1'b0, irq_period_q}) begin
            irq_sum    = irq_sum - {1'b0, irq_period_q};
            irq_pend_d = 1'b1;
          end
          irq_cnt_d = irq_sum[11:0];
          if (firq_pend_q) begin
            firq_out    = 1'b1;
            firq_pend_d = 1'b0;
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q      <= PageReset;
      mux_one_q   <= '0;
      mux_two_q   <= '0;
      lock_q      <= LockReset;
      wd_q        <= '0;
      tdiv_q      <= '0;
      irq_cnt_q   <= '0;
      irq_pend_q  <= 1'b0;
      firq_pend_q <= 1'b0;
    end else if (advance) begin
      page_q      <= page_d;
      mux_one_q   <= mux_one_d;
      mux_two_q   <= mux_two_d;
      lock_q      <= lock_d;
      wd_q        <= wd_d;
      tdiv_q      <= tdiv_d;
      irq_cnt_q   <= irq_cnt_d;
      irq_pend_q  <= irq_pend_d;
      firq_pend_q <= firq_pend_d;
    end
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'd0, rst_req, firq_out, irq_pend_d, snd, rd, fwd, base, col, phys,
                     tgt};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // a request parked in stage 1 is never dropped while the result side stalls
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("stage 1 request lost during stall");

  // a watchdog reset puts the locks and the watchdog back to power-up
  a_wd_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rst_req |=> lock_q == LockReset && wd_q == 9'd0 && !irq_pend_q)
    else $error("watchdog reset left stale state");

  // a reset result never carries an interrupt
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OutRstBit] |->
      !m_axis_tdata[OutFirqBit] && !m_axis_tdata[OutIrqBit])
    else $error("interrupt reported with watchdog reset");

endmodule
